// ----- design/latency_stats_topk_monitor_top_defines.svh -----
// Assertion macros shared by the latency monitor RTL.
`ifndef LATENCY_STATS_TOPK_MONITOR_TOP_DEFINES_SVH
`define LATENCY_STATS_TOPK_MONITOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge outside of reset.
`define LSTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("latency monitor check failed");
// Checked at every clock edge, reset included.
`define LSTM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("latency monitor check failed");
`else
`define LSTM_ASSERT(lbl, prop)
`define LSTM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- design/lstm_pkg.sv -----
`timescale 1ns / 1ps
package lstm_pkg;
  // Fixed field widths.
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int TS_W   = 32;
  localparam int STAT_W = 2;
  localparam int OUT_W  = 32;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;

  // Parameter defaults.
  localparam int SLOTS_DEF     = 16;
  localparam int KEEP_DEF      = 4;
  localparam int TIME_BITS_DEF = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_END_IGN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_DATA = 2'd2;
endpackage

// ----- design/lstm_mem.sv -----
`timescale 1ns / 1ps
module lstm_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);
  logic [W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- design/lstm_div.sv -----
`timescale 1ns / 1ps
module lstm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lstm_pkg::SUM_W-1:0] num,
  input  logic [lstm_pkg::CNT_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [lstm_pkg::SUM_W-1:0] quot
);
  import lstm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Shift in one numerator bit and try the subtraction.
  always_comb begin
    trial = {rem, quot[SUM_W-1]};
    fits  = trial >= {1'b0, den};
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
        rem   <= '0;
        quot  <= num;
      end else if (busy) begin
        rem   <= fits ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
        quot  <= {quot[SUM_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/latency_stats_topk_monitor_top.sv -----
`timescale 1ns / 1ps
// Channel | Handshake          | Payload
// in      | in_valid, in_stall | cmd, slot, timestamp
// out     | out_valid,out_stall| status, average, fastest, slowest, calls, total
//
// Begin, end and clear pass the read, execute and done states before a result is written to the output register.
// A query without data takes the same path; with data it adds the drop state when trimmed
// and then waits on the bit-serial divider, which takes one bit of the 48-bit sum per cycle.
// Each item reads one slot row from the slot memory; begin and end write the modified row back.
// Reset clears the open flags, the control state and the output valid; no clearing pass.
// A new item is taken while a result waits; a stalled output holds the next result.
module latency_stats_topk_monitor_top #(
  parameter int SLOTS     = lstm_pkg::SLOTS_DEF,
  parameter int KEEP      = lstm_pkg::KEEP_DEF,
  parameter int TIME_BITS = lstm_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lstm_pkg::CMD_W-1:0]  cmd,
  input  logic [lstm_pkg::SLOT_W-1:0] slot,
  input  logic [lstm_pkg::TS_W-1:0]   timestamp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lstm_pkg::STAT_W-1:0] status,
  output logic [lstm_pkg::OUT_W-1:0]  average,
  output logic [lstm_pkg::OUT_W-1:0]  fastest,
  output logic [lstm_pkg::OUT_W-1:0]  slowest,
  output logic [lstm_pkg::CNT_W-1:0]  calls,
  output logic [lstm_pkg::SUM_W-1:0]  total
);
  import lstm_pkg::*;
`include "latency_stats_topk_monitor_top_defines.svh"

  localparam int TB       = TIME_BITS;
  localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIDX_W   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int KAW      = (KEEP > 1) ? $clog2(KEEP) : 1;
  localparam int SUM_OFF  = TB;
  localparam int CNT_OFF  = TB + SUM_W;
  localparam int LOW_OFF  = CNT_OFF + CNT_W;
  localparam int HIGH_OFF = LOW_OFF + KEEP * TB;
  localparam int ROW_W    = HIGH_OFF + KEEP * TB;
  localparam int DROP_W   = TB + 2 + KAW;
  localparam int CMP_W    = (DROP_W > SUM_W) ? DROP_W : SUM_W;
  localparam int EXT_W    = (TB > OUT_W) ? TB : OUT_W;
  localparam int VAL_W    = KAW + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DROP, ST_DIV, ST_DONE
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [SIDX_W-1:0]   slot_q;
  logic [TB-1:0]       ts_q;
  logic [SLOTS-1:0]    slot_open;
  logic [STAT_W-1:0]   res_status;
  logic [OUT_W-1:0]    res_average;
  logic [OUT_W-1:0]    res_fastest;
  logic [OUT_W-1:0]    res_slowest;
  logic [CNT_W-1:0]    res_calls;
  logic [SUM_W-1:0]    res_total;
  logic [KAW-1:0]      kidx;
  logic [DROP_W-1:0]   drop;

  logic [AW-1:0]       addr;
  logic                in_range;
  logic                is_open;
  logic                q_stats;
  logic                q_trim;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    wr_row;
  logic                wr_en;

  logic [TB-1:0]       stamp;
  logic [SUM_W-1:0]    sum_old;
  logic [CNT_W-1:0]    cnt_old;
  logic [TB-1:0]       low_old  [KEEP];
  logic [TB-1:0]       high_old [KEEP];
  logic [TB-1:0]       low_new  [KEEP];
  logic [TB-1:0]       high_new [KEEP];
  logic [KEEP-1:0]     take_low;
  logic [KEEP-1:0]     take_high;
  logic [TB-1:0]       elapsed;
  logic [VAL_W-1:0]    filled;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [DROP_W-1:0]   drop_next;
  logic [SUM_W-1:0]    trimmed;

  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [SUM_W-1:0]    div_num;
  logic [CNT_W-1:0]    div_den;
  logic [SUM_W-1:0]    div_quot;

  // Clamp a tick value to the 32-bit result range.
  function automatic logic [OUT_W-1:0] sat_out(input logic [TB-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    sat_out = (ext > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
  endfunction

  // Slot decode from the latched request.
  assign addr     = slot_q[AW-1:0];
  assign in_range = {1'b0, slot_q} < (SIDX_W + 1)'(SLOTS);
  assign is_open  = in_range && slot_open[addr];

  // A query reports statistics only for an open slot with calls.
  assign q_stats = (cmd_q == CMD_QUERY) && is_open && (cnt_old != '0);
  assign q_trim  = q_stats && (cnt_old > CNT_W'(2 * KEEP));

  lstm_mem #(.DEPTH(SLOTS), .AW(AW), .W(ROW_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_row),
    .rd_en   (state == ST_READ),
    .rd_addr (addr),
    .rd_data (rd_row)
  );

  // Unpack the slot row.
  always_comb begin
    stamp   = rd_row[TB-1:0];
    sum_old = rd_row[SUM_OFF +: SUM_W];
    cnt_old = rd_row[CNT_OFF +: CNT_W];
    for (int i = 0; i < KEEP; i++) begin
      low_old[i]  = rd_row[LOW_OFF + i * TB +: TB];
      high_old[i] = rd_row[HIGH_OFF + i * TB +: TB];
    end
  end

  // Elapsed time, saturating total and count, and list fill level.
  always_comb begin
    elapsed  = ts_q - stamp;
    sum_wide = {1'b0, sum_old} + (SUM_W + 1)'(elapsed);
    sum_new  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    cnt_new  = (cnt_old == {CNT_W{1'b1}}) ? cnt_old : cnt_old + 1'b1;
    filled   = (cnt_old < CNT_W'(KEEP)) ? VAL_W'(cnt_old) : VAL_W'(KEEP);
  end

  // Sorted insertion; the take flags are monotonic along each list.
  always_comb begin
    for (int i = 0; i < KEEP; i++) begin
      take_low[i]  = (VAL_W'(i) >= filled) || (elapsed < low_old[i]);
      take_high[i] = (VAL_W'(i) >= filled) || (elapsed > high_old[i]);
    end
    for (int j = 0; j < KEEP; j++) begin
      if (!take_low[j]) begin
        low_new[j] = low_old[j];
      end else if (j == 0) begin
        low_new[j] = elapsed;
      end else begin
        low_new[j] = take_low[j-1] ? low_old[j-1] : elapsed;
      end
      if (!take_high[j]) begin
        high_new[j] = high_old[j];
      end else if (j == 0) begin
        high_new[j] = elapsed;
      end else begin
        high_new[j] = take_high[j-1] ? high_old[j-1] : elapsed;
      end
    end
  end

  // Row to write back: a fresh row for a first begin, an updated row for an end.
  always_comb begin
    wr_row = rd_row;
    wr_en  = 1'b0;
    if (state == ST_EXEC) begin
      unique case (cmd_q) inside
        CMD_BEGIN: begin
          wr_en = in_range;
          wr_row[TB-1:0] = ts_q;
          if (!is_open) begin
            wr_row[SUM_OFF +: SUM_W] = '0;
            wr_row[CNT_OFF +: CNT_W] = '0;
            for (int i = 0; i < KEEP; i++) begin
              wr_row[LOW_OFF + i * TB +: TB]  = {TB{1'b1}};
              wr_row[HIGH_OFF + i * TB +: TB] = '0;
            end
          end
        end
        CMD_END: begin
          wr_en = is_open;
          wr_row[SUM_OFF +: SUM_W] = sum_new;
          wr_row[CNT_OFF +: CNT_W] = cnt_new;
          for (int i = 0; i < KEEP; i++) begin
            wr_row[LOW_OFF + i * TB +: TB]  = low_new[i];
            wr_row[HIGH_OFF + i * TB +: TB] = high_new[i];
          end
        end
        CMD_QUERY, CMD_CLEAR: begin
          wr_en = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Trimming sum, one low and one high entry per cycle.
  always_comb begin
    drop_next = drop + DROP_W'(low_old[kidx]) + DROP_W'(high_old[kidx]);
    trimmed   = (CMP_W'(drop_next) > CMP_W'(sum_old)) ? '0
              : SUM_W'(CMP_W'(sum_old) - CMP_W'(drop_next));
  end

  lstm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_stall = (state != ST_IDLE);

  // Sequencer, open flags and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot_open <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= ((state == ST_EXEC) && q_stats && !q_trim)
                || ((state == ST_DROP) && (kidx == KAW'(KEEP - 1)));
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            slot_q <= SIDX_W'(slot);
            ts_q   <= TB'(timestamp);
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          res_average <= '0;
          res_fastest <= q_stats ? sat_out(low_old[0]) : '0;
          res_slowest <= q_stats ? sat_out(high_old[0]) : '0;
          res_calls   <= q_stats ? cnt_old : '0;
          res_total   <= q_stats ? sum_old : '0;
          if (cmd_q == CMD_END && !is_open) begin
            res_status <= STAT_END_IGN;
          end else if (cmd_q == CMD_QUERY && !q_stats) begin
            res_status <= STAT_NO_DATA;
          end else begin
            res_status <= STAT_OK;
          end
          if (cmd_q == CMD_BEGIN && in_range) begin
            slot_open[addr] <= 1'b1;
          end else if (cmd_q == CMD_CLEAR) begin
            slot_open <= '0;
          end
          if (q_trim) begin
            kidx  <= '0;
            drop  <= '0;
            state <= ST_DROP;
          end else if (q_stats) begin
            div_num <= sum_old;
            div_den <= cnt_old;
            state   <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DROP: begin
          drop <= drop_next;
          kidx <= kidx + 1'b1;
          if (kidx == KAW'(KEEP - 1)) begin
            div_num   <= trimmed;
            div_den   <= cnt_old - CNT_W'(2 * KEEP);
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_average <= (div_quot > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                         : div_quot[OUT_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            status    <= res_status;
            average   <= res_average;
            fastest   <= res_fastest;
            slowest   <= res_slowest;
            calls     <= res_calls;
            total     <= res_total;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new result appears only from the completion state.
  `LSTM_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state) == ST_DONE)
  // The divider only runs while the sequencer waits for it.
  `LSTM_ASSERT(a_div_in_div_state, div_busy |-> state == ST_DIV)
  // A non-ok result never carries an average.
  `LSTM_ASSERT(a_status_zero_avg, (out_valid && status != STAT_OK) |-> average == '0)
  // Reset leaves the sequencer idle, with the input not stalled.
  `LSTM_ASSERT_ALWAYS(a_reset_idle, rst |=> !in_stall)
endmodule
